/* design/csc2d_pkg.sv */
package csc2d_pkg;

   localparam int FIELD_W = 11;
   localparam int VALUE_W = 64;

   typedef logic [1:0] cmd_type;
   typedef logic [2:0] status_type;
   typedef logic [1:0] csr_index_type;

   localparam cmd_type CMD_BEGIN   = 2'd0;
   localparam cmd_type CMD_POINTER = 2'd1;
   localparam cmd_type CMD_ENTRY   = 2'd2;
   localparam cmd_type CMD_READ    = 2'd3;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_BAD_ROW  = 3'd1;
   localparam status_type ST_OVERFLOW = 3'd2;
   localparam status_type ST_BAD_READ = 3'd3;
   localparam status_type ST_SIZE     = 3'd4;

   localparam csr_index_type CSR_NUM_ROWS     = 2'd0;
   localparam csr_index_type CSR_NUM_COLS     = 2'd1;
   localparam csr_index_type CSR_COMPLEX_MODE = 2'd2;

endpackage

/* design/sparse_csc_to_dense.sv */
// Expands a compressed-sparse-column matrix into a dense column-major store of
// MAX_ELEMS elements (a 128-bit single-port memory holding real and imaginary
// parts) with a column-start table of MAX_COLS+1 entries in a second memory.
// Each request yields exactly one response. After reset the block runs a
// clearing pass over the dense store with req_ready low; a begin request
// runs the same pass before its response. A pointer is written straight to
// the table; a read goes through S_MUL and S_ADDR and a registered memory
// read; an entry first walks the columns, stepping past a column without a
// loaded end pointer directly and past other columns by comparing against
// the registered start-table read in S_WCMP. A finished response sits
// in an output register, so the next request is taken while it waits.
module sparse_csc_to_dense
   import csc2d_pkg::*;
#(
   parameter int MAX_ELEMS = 1024,
   parameter int MAX_COLS  = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [FIELD_W-1:0]   req_index_value,
   input  logic [FIELD_W-1:0]   req_col_index,
   input  logic [VALUE_W-1:0]   req_value_real,
   input  logic [VALUE_W-1:0]   req_value_imag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [VALUE_W-1:0]   rsp_read_real,
   output logic [VALUE_W-1:0]   rsp_read_imag,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata
);

   localparam int AW   = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam int TW   = $clog2(MAX_COLS + 1);
   localparam int PW   = $clog2(MAX_COLS + 2);
   localparam int EW   = $clog2(MAX_ELEMS + 1);
   localparam int MW0  = (PW > EW) ? PW : EW;
   localparam int MW1  = (MW0 > FIELD_W) ? MW0 : FIELD_W;
   localparam int CMPW = MW1 + 1;
   localparam int PRW  = 2 * FIELD_W;
   localparam int ADW  = PRW + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_WCMP  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_ADDR  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   // control registers
   logic [2:0]         state_ff, state_in;
   logic [FIELD_W-1:0] nrows_ff, nrows_in;
   logic [FIELD_W-1:0] ncols_ff, ncols_in;
   logic               cplx_ff, cplx_in;
   logic [PW-1:0]      pcnt_ff, pcnt_in;
   logic [EW-1:0]      ecnt_ff, ecnt_in;
   logic [TW-1:0]      ccol_ff, ccol_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   cmd_type            cmd_ff, cmd_in;
   logic [FIELD_W-1:0] idx_ff, idx_in;
   logic [FIELD_W-1:0] col_ff, col_in;
   logic [VALUE_W-1:0] re_ff, re_in;
   logic [VALUE_W-1:0] im_ff, im_in;
   status_type         stat_ff, stat_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [PRW-1:0]     mul_ff, mul_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_real_ff, rsp_real_in;
   logic [VALUE_W-1:0] rsp_imag_ff, rsp_imag_in;

   // memories
   logic [FIELD_W-1:0]     cstart_mem [MAX_COLS+1];
   logic [FIELD_W-1:0]     cstart_q_ff;
   logic [2*VALUE_W-1:0]   dense_mem [MAX_ELEMS];
   logic [2*VALUE_W-1:0]   dense_q_ff;

   logic                 tbl_we, tbl_re;
   logic [TW-1:0]        tbl_waddr, tbl_raddr;
   logic                 dn_we, dn_re;
   logic [AW-1:0]        dn_addr;
   logic [2*VALUE_W-1:0] dn_wdata;

   logic [PRW-1:0]     prod;
   logic               size_ok;
   logic               req_fire;
   logic [TW:0]        ccol_inc;
   logic [FIELD_W-1:0] mul_a;
   logic [ADW-1:0]     addr;

   assign prod     = PRW'(nrows_ff) * PRW'(ncols_ff);
   assign size_ok  = (ADW'(prod) <= ADW'(MAX_ELEMS)) && (CMPW'(ncols_ff) <= CMPW'(MAX_COLS));
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign ccol_inc  = {1'b0, ccol_ff} + 1'b1;
   assign mul_a     = (cmd_ff == CMD_READ) ? (col_ff - 1'b1) : FIELD_W'(ccol_ff);
   assign addr      = ADW'(idx_ff - 1'b1) + ADW'(mul_ff);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_real = rsp_real_ff;
   assign rsp_read_imag = rsp_imag_ff;

   always_comb begin
      state_in      = state_ff;
      nrows_in      = nrows_ff;
      ncols_in      = ncols_ff;
      cplx_in       = cplx_ff;
      pcnt_in       = pcnt_ff;
      ecnt_in       = ecnt_ff;
      ccol_in       = ccol_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      re_in         = re_ff;
      im_in         = im_ff;
      stat_in       = stat_ff;
      rd_ok_in      = rd_ok_ff;
      mul_in        = mul_ff;
      rsp_status_in = rsp_status_ff;
      rsp_real_in   = rsp_real_ff;
      rsp_imag_in   = rsp_imag_ff;
      tbl_we        = 1'b0;
      tbl_re        = 1'b0;
      tbl_waddr     = pcnt_ff[TW-1:0];
      tbl_raddr     = ccol_inc[TW-1:0];
      dn_we         = 1'b0;
      dn_re         = 1'b0;
      dn_addr       = addr[AW-1:0];
      dn_wdata      = {(cplx_ff ? im_ff : {VALUE_W{1'b0}}), re_ff};

      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_ROWS:     nrows_in = csr_wdata;
            CSR_NUM_COLS:     ncols_in = csr_wdata;
            CSR_COMPLEX_MODE: cplx_in  = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_cmd;
               idx_in   = req_index_value;
               col_in   = req_col_index;
               re_in    = req_value_real;
               im_in    = req_value_imag;
               rd_ok_in = 1'b0;
               state_in = S_RESP;
               case (req_cmd)
                  CMD_BEGIN: begin
                     pcnt_in     = '0;
                     ecnt_in     = '0;
                     ccol_in     = '0;
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     stat_in     = size_ok ? ST_OK : ST_SIZE;
                     state_in    = S_CLEAR;
                  end
                  CMD_POINTER: begin
                     if (!size_ok) begin
                        stat_in = ST_SIZE;
                     end else if (CMPW'(pcnt_ff) >= CMPW'(ncols_ff) + 1'b1) begin
                        stat_in = ST_OVERFLOW;
                     end else if (req_index_value == '0 ||
                                  ADW'(req_index_value) > ADW'(prod) + 1'b1) begin
                        stat_in = ST_OVERFLOW;
                     end else begin
                        tbl_we  = 1'b1;
                        pcnt_in = pcnt_ff + 1'b1;
                        stat_in = ST_OK;
                     end
                  end
                  CMD_ENTRY: begin
                     if (!size_ok) begin
                        stat_in = ST_SIZE;
                     end else if (CMPW'(ecnt_ff) >= CMPW'(MAX_ELEMS)) begin
                        stat_in = ST_OVERFLOW;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     if (!size_ok || req_index_value == '0 || req_index_value > nrows_ff ||
                         req_col_index == '0 || req_col_index > ncols_ff) begin
                        stat_in = ST_BAD_READ;
                     end else begin
                        state_in = S_MUL;
                     end
                  end
               endcase
            end
         end
         S_CLEAR: begin
            dn_we    = 1'b1;
            dn_addr  = clr_addr_ff;
            dn_wdata = '0;
            if (clr_addr_ff == AW'(MAX_ELEMS - 1)) begin
               state_in = clr_rsp_ff ? S_RESP : S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_WALK: begin
            if (CMPW'(ccol_ff) < CMPW'(ncols_ff)) begin
               // a column without a loaded end pointer counts as ended
               if (CMPW'(ccol_inc) >= CMPW'(pcnt_ff)) begin
                  ccol_in = ccol_inc[TW-1:0];
               end else begin
                  tbl_re   = 1'b1;
                  state_in = S_WCMP;
               end
            end else begin
               stat_in  = ST_OVERFLOW;
               state_in = S_RESP;
            end
         end
         S_WCMP: begin
            if (CMPW'(ecnt_ff) + 1'b1 >= CMPW'(cstart_q_ff)) begin
               ccol_in  = ccol_inc[TW-1:0];
               state_in = S_WALK;
            end else begin
               ecnt_in = ecnt_ff + 1'b1;
               if (idx_ff == '0 || idx_ff > nrows_ff) begin
                  stat_in  = ST_BAD_ROW;
                  state_in = S_RESP;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            mul_in   = PRW'(mul_a) * PRW'(nrows_ff);
            state_in = S_ADDR;
         end
         S_ADDR: begin
            state_in = S_RESP;
            if (addr >= ADW'(MAX_ELEMS)) begin
               stat_in = (cmd_ff == CMD_READ) ? ST_BAD_READ : ST_BAD_ROW;
            end else if (cmd_ff == CMD_READ) begin
               dn_re    = 1'b1;
               rd_ok_in = 1'b1;
               stat_in  = ST_OK;
            end else begin
               dn_we   = 1'b1;
               stat_in = ST_OK;
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_real_in   = rd_ok_ff ? dense_q_ff[VALUE_W-1:0] : '0;
               rsp_imag_in   = (rd_ok_ff && cplx_ff) ? dense_q_ff[2*VALUE_W-1:VALUE_W] : '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         nrows_ff     <= FIELD_W'(1);
         ncols_ff     <= FIELD_W'(1);
         cplx_ff      <= 1'b0;
         pcnt_ff      <= '0;
         ecnt_ff      <= '0;
         ccol_ff      <= '0;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nrows_ff     <= nrows_in;
         ncols_ff     <= ncols_in;
         cplx_ff      <= cplx_in;
         pcnt_ff      <= pcnt_in;
         ecnt_ff      <= ecnt_in;
         ccol_ff      <= ccol_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      col_ff        <= col_in;
      re_ff         <= re_in;
      im_ff         <= im_in;
      stat_ff       <= stat_in;
      rd_ok_ff      <= rd_ok_in;
      mul_ff        <= mul_in;
      rsp_status_ff <= rsp_status_in;
      rsp_real_ff   <= rsp_real_in;
      rsp_imag_ff   <= rsp_imag_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         cstart_mem[tbl_waddr] <= req_index_value;
      end
      if (tbl_re) begin
         cstart_q_ff <= cstart_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dn_we) begin
         dense_mem[dn_addr] <= dn_wdata;
      end
      if (dn_re) begin
         dense_q_ff <= dense_mem[dn_addr];
      end
   end

endmodule
